[rtl/ffba_pkg.sv]
// ffba_pkg: types, constants and codes shared by the first-fit block allocator.
// Depends on nothing; used by ffba_chunk_ram, the allocator and its testbench.
package ffba_pkg;

    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 29;
    localparam int START_W     = 20;
    localparam int LEN_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int BLOCK_BYTES = 256;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int MAX_CHUNKS  = 64;
    localparam int POOL_RESET  = 16384;
    localparam int POOL_MAX    = 1048576;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS  = 2'd1;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } chunk_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic init;
    } ram_ctrl_t;

endpackage

[rtl/ffba_chunk_ram.sv]
// ffba_chunk_ram: free-list chunk memory with registered read.
// Entry zero reads as the whole pool until first written. Depends on ffba_pkg.
module ffba_chunk_ram #(
    parameter int DEPTH = ffba_pkg::MAX_CHUNKS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffba_pkg::ram_ctrl_t             ctrl,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  ffba_pkg::chunk_t                wr_data,
    input  logic [ffba_pkg::LEN_W-1:0]      pool,
    output ffba_pkg::chunk_t                rd_data
);

    localparam int AW = $clog2(DEPTH);

    ffba_pkg::chunk_t mem [DEPTH];
    ffba_pkg::chunk_t rd_data_reg;
    logic             entry0_pool_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            if (entry0_pool_reg && rd_addr == AW'(0))
            begin
                rd_data_reg <= '{start: '0, len: pool};
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    // hold entry zero at the full pool until it is overwritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry0_pool_reg <= 1'b1;
        end
        else if (ctrl.init)
        begin
            entry0_pool_reg <= 1'b1;
        end
        else if (ctrl.wr_en && wr_addr == AW'(0))
        begin
            entry0_pool_reg <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/first_fit_block_allocator.sv]
// first_fit_block_allocator: first-fit pool allocator over a sorted,
// coalescing free list. Depends on ffba_pkg and ffba_chunk_ram.
// A request that decode settles goes straight to the result; an allocate walks
// the list to the first chunk that fits, and if it empties that chunk, shifts the
// later chunks down; a free streams the whole list with the new chunk merged in.
// One transaction is in work at a time; the next is accepted the cycle after the
// result is loaded. Reset: one free chunk covering 16384 blocks, base address zero.
module first_fit_block_allocator #(
    parameter int MAX_CHUNKS = ffba_pkg::MAX_CHUNKS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ffba_pkg::req_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ffba_pkg::rsp_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]        cfg_data
);

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int AW = ffba_pkg::ADDR_W;
    localparam int SW = ffba_pkg::START_W;
    localparam int LW = ffba_pkg::LEN_W;
    localparam int NW = ffba_pkg::SIZE_W;

    // Sequencer: A_* walk for allocate, D_* shift down after removing an
    // emptied chunk, F_* stream the list with the new chunk merged in.
    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_A_RD    = 10'b0000000010,
        S_A_PROC  = 10'b0000000100,
        S_D_RD    = 10'b0000001000,
        S_D_PROC  = 10'b0000010000,
        S_F_RD    = 10'b0000100000,
        S_F_PROC  = 10'b0001000000,
        S_F_END   = 10'b0010000000,
        S_F_FLUSH = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] base_reg;
    logic [LW-1:0] pool_reg;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] wp_reg, wp_next;
    logic          have_prev_reg, have_prev_next;
    logic          inserted_reg, inserted_next;
    ffba_pkg::chunk_t prev_reg, prev_next;

    // latched request
    logic [NW-1:0] need_reg;
    ffba_pkg::chunk_t new_reg;

    // pending result
    logic          res_ok_reg, res_ok_next;
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [1:0]    res_status_reg, res_status_next;

    logic          out_valid_reg;
    ffba_pkg::rsp_t out_data_reg;

    ffba_pkg::ram_ctrl_t ram_ctrl;
    logic [IW-1:0]       ram_rd_addr, ram_wr_addr;
    ffba_pkg::chunk_t    ram_wr_data, ram_rd_data;

    // request decode
    logic [NW:0]   need_w;
    logic [NW-1:0] need;
    logic [AW-1:0] offset;
    logic [AW-1:0] head;
    logic          free_outside;
    logic          in_take, cfg_take, out_take;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_take  = out_valid_reg && out_ready;

    assign need_w = ({1'b0, in_data.size_bytes} + (NW + 1)'(ffba_pkg::BLOCK_BYTES - 1))
                    >> ffba_pkg::BLOCK_SHIFT;
    assign need   = need_w[NW-1:0];
    assign offset = in_data.block_address - base_reg;
    assign head   = offset >> ffba_pkg::BLOCK_SHIFT;
    assign free_outside = (head >= AW'(pool_reg))
                       || ((AW + 1)'(need) > ((AW + 1)'(pool_reg) - (AW + 1)'(head)));

    ffba_chunk_ram #(
        .DEPTH (MAX_CHUNKS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ram_ctrl),
        .rd_addr (ram_rd_addr),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .pool    (pool_reg),
        .rd_data (ram_rd_data)
    );

    // element fed to the merge stream this cycle
    logic             take_new;
    logic             absorb_en;
    ffba_pkg::chunk_t elem;
    logic [LW:0]      prev_end;

    always_comb
    begin
        take_new  = (state_reg == S_F_PROC && !inserted_reg && ram_rd_data.start > new_reg.start)
                 || (state_reg == S_F_END);
        absorb_en = (state_reg == S_F_PROC) || (state_reg == S_F_END && !inserted_reg);
        elem      = take_new ? new_reg : ram_rd_data;
        prev_end  = (LW + 1)'(prev_reg.start) + (LW + 1)'(prev_reg.len);
    end

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        wp_next         = wp_reg;
        have_prev_next  = have_prev_reg;
        inserted_next   = inserted_reg;
        prev_next       = prev_reg;
        res_ok_next     = res_ok_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        ram_ctrl        = '0;
        ram_rd_addr     = idx_reg[IW-1:0];
        ram_wr_addr     = idx_reg[IW-1:0];
        ram_wr_data     = ram_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    res_ok_next     = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = ffba_pkg::ST_NOFIT;
                    idx_next        = '0;
                    wp_next         = '0;
                    have_prev_next  = 1'b0;
                    inserted_next   = 1'b0;
                    if (in_data.cmd == ffba_pkg::CMD_ALLOC)
                    begin
                        state_next = (NW'(pool_reg) < need) ? S_DONE : S_A_RD;
                    end
                    else if (need == '0)
                    begin
                        res_ok_next     = 1'b1;
                        res_status_next = ffba_pkg::ST_OK;
                        state_next      = S_DONE;
                    end
                    else if (free_outside)
                    begin
                        state_next = S_DONE;
                    end
                    else if (total_reg >= CW'(MAX_CHUNKS))
                    begin
                        res_status_next = ffba_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_A_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_ctrl.rd_en = 1'b1;
                    state_next     = S_A_PROC;
                end
            end
            S_A_PROC:
            begin
                if (NW'(ram_rd_data.len) >= need_reg)
                begin
                    res_ok_next     = 1'b1;
                    res_status_next = ffba_pkg::ST_OK;
                    res_addr_next   = base_reg
                                    + (AW'(ram_rd_data.start) << ffba_pkg::BLOCK_SHIFT);
                    if (NW'(ram_rd_data.len) != need_reg)
                    begin
                        ram_ctrl.wr_en    = 1'b1;
                        ram_wr_data.start = ram_rd_data.start + SW'(need_reg);
                        ram_wr_data.len   = ram_rd_data.len - LW'(need_reg);
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        // emptied: close the gap
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_D_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_A_RD;
                end
            end
            S_D_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    total_next = total_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_ctrl.rd_en = 1'b1;
                    state_next     = S_D_PROC;
                end
            end
            S_D_PROC:
            begin
                ram_ctrl.wr_en = 1'b1;
                ram_wr_addr    = IW'(idx_reg - CW'(1));
                idx_next       = idx_reg + CW'(1);
                state_next     = S_D_RD;
            end
            S_F_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    state_next = S_F_END;
                end
                else
                begin
                    ram_ctrl.rd_en = 1'b1;
                    state_next     = S_F_PROC;
                end
            end
            S_F_PROC:
            begin
                if (take_new)
                begin
                    // new chunk goes ahead; revisit the same read data
                    inserted_next = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_F_RD;
                end
            end
            S_F_END:
            begin
                inserted_next = 1'b1;
                state_next    = S_F_FLUSH;
            end
            S_F_FLUSH:
            begin
                ram_ctrl.wr_en  = 1'b1;
                ram_wr_addr     = wp_reg;
                ram_wr_data     = prev_reg;
                total_next      = CW'(wp_reg) + CW'(1);
                res_ok_next     = 1'b1;
                res_status_next = ffba_pkg::ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // merge stream: extend the held chunk or retire it
        if (absorb_en)
        begin
            if (have_prev_reg && prev_end == (LW + 1)'(elem.start))
            begin
                prev_next.len = prev_reg.len + elem.len;
            end
            else
            begin
                if (have_prev_reg)
                begin
                    ram_ctrl.wr_en = 1'b1;
                    ram_wr_addr    = wp_reg;
                    ram_wr_data    = prev_reg;
                    wp_next        = wp_reg + IW'(1);
                end
                prev_next      = elem;
                have_prev_next = 1'b1;
            end
        end

        // pool write resets the list to one chunk
        if (cfg_take && cfg_index == ffba_pkg::REG_POOL_BLOCKS)
        begin
            ram_ctrl.init = 1'b1;
            total_next    = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= CW'(1);
            base_reg      <= '0;
            pool_reg      <= LW'(ffba_pkg::POOL_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (cfg_take)
            begin
                case (cfg_index)
                    ffba_pkg::REG_BASE_ADDRESS: base_reg <= cfg_data;
                    ffba_pkg::REG_POOL_BLOCKS:
                    begin
                        if (cfg_data[LW-1:0] == '0)
                        begin
                            pool_reg <= LW'(1);
                        end
                        else if (cfg_data[LW-1:0] > LW'(ffba_pkg::POOL_MAX))
                        begin
                            pool_reg <= LW'(ffba_pkg::POOL_MAX);
                        end
                        else
                        begin
                            pool_reg <= cfg_data[LW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wp_reg         <= wp_next;
        have_prev_reg  <= have_prev_next;
        inserted_reg   <= inserted_next;
        prev_reg       <= prev_next;
        res_ok_reg     <= res_ok_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (in_take)
        begin
            need_reg      <= need;
            new_reg.start <= head[SW-1:0];
            new_reg.len   <= need[LW-1:0];
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_data_reg.ok              <= res_ok_reg;
            out_data_reg.granted_address <= res_addr_reg;
            out_data_reg.status          <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[verif/first_fit_block_allocator_tb.sv]
// Self-checking testbench for first_fit_block_allocator: directed table, then
// constrained-by-hand random alloc/free traffic under several idle/stall mixes.
// Depends on rtl/ffba_pkg.sv and the allocator RTL only.
module first_fit_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = ffba_pkg::ADDR_W;
    localparam int SIZE_W      = ffba_pkg::SIZE_W;
    localparam int START_W     = ffba_pkg::START_W;
    localparam int LEN_W       = ffba_pkg::LEN_W;
    localparam int CFG_IDX_W   = ffba_pkg::CFG_IDX_W;
    localparam int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES;
    localparam int MAX_CHUNKS  = ffba_pkg::MAX_CHUNKS;
    localparam int POOL_MAX    = ffba_pkg::POOL_MAX;

    localparam int SETTLE_CYC = 2 * MAX_CHUNKS + 200;
    localparam int CYCLE_CAP  = 2000000;
    localparam int SHOWN_MAX  = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    ffba_pkg::req_t       in_data;
    logic                 out_valid;
    logic                 out_ready;
    ffba_pkg::rsp_t       out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    first_fit_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-list mirror: sorted chunks of (head block, length in blocks).
    logic [ADDR_W-1:0] pool_base;
    logic [LEN_W-1:0]  pool_size;
    logic [START_W:0]  chunk_head [MAX_CHUNKS];
    logic [LEN_W:0]    chunk_len  [MAX_CHUNKS];
    int                chunk_count;

    ffba_pkg::rsp_t pending_grants[$];
    int   mismatch_count = 0;
    bit   broken = 1'b0;
    int   cycle_count = 0;
    int   sender_idle_pct;
    int   sink_stall_pct;

    // Live allocations, kept so most frees release something really granted.
    logic [ADDR_W-1:0] live_addr[$];
    logic [SIZE_W-1:0] live_bytes[$];

    typedef struct {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] block_address;
        bit                typed;
        ffba_pkg::rsp_t    want;
    } row_t;

    row_t rows[$];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop: no correct run gets anywhere near this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: stall at the rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void reset_list();
        for (int k = 0; k < MAX_CHUNKS; k++)
        begin
            chunk_head[k] = '0;
            chunk_len[k]  = '0;
        end
        chunk_len[0] = (LEN_W + 1)'(pool_size);
        chunk_count  = 1;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        logic [LEN_W-1:0] v;
        if (idx == ffba_pkg::REG_BASE_ADDRESS)
        begin
            pool_base = val;
        end
        else if (idx == ffba_pkg::REG_POOL_BLOCKS)
        begin
            // Saturate to 1..POOL_MAX, then rebuild a single whole-pool chunk.
            v = val[LEN_W-1:0];
            if (v == '0)
                v = LEN_W'(1);
            if (v > LEN_W'(POOL_MAX))
                v = LEN_W'(POOL_MAX);
            pool_size = v;
            reset_list();
        end
    endfunction

    // Compute the response of one request and advance the free-list mirror.
    function automatic ffba_pkg::rsp_t predict_grant(ffba_pkg::req_t r);
        ffba_pkg::rsp_t    o;
        logic [63:0]       need;
        logic [ADDR_W-1:0] offs;
        logic [63:0]       head;
        int                pos;
        int                p;
        int                c;
        bit                done;
        o.ok              = 1'b0;
        o.granted_address = '0;
        o.status          = ffba_pkg::ST_NOFIT;
        need = (64'(r.size_bytes) + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
        done = 1'b0;
        if (r.cmd == ffba_pkg::CMD_ALLOC)
        begin
            if (need <= 64'(pool_size))
            begin
                for (int k = 0; k < chunk_count && !done; k++)
                begin
                    if (64'(chunk_len[k]) >= need)
                    begin
                        done = 1'b1;
                        o.ok = 1'b1;
                        o.status = ffba_pkg::ST_OK;
                        o.granted_address = pool_base
                                          + ADDR_W'(chunk_head[k]) * ADDR_W'(BLOCK_BYTES);
                        chunk_head[k] = chunk_head[k] + (START_W + 1)'(need);
                        chunk_len[k]  = chunk_len[k] - (LEN_W + 1)'(need);
                        if (chunk_len[k] == '0)
                        begin
                            for (int j = k; j < chunk_count - 1; j++)
                            begin
                                chunk_head[j] = chunk_head[j + 1];
                                chunk_len[j]  = chunk_len[j + 1];
                            end
                            chunk_count--;
                        end
                    end
                end
            end
            return o;
        end
        offs = r.block_address - pool_base;
        head = 64'(offs) / 64'(BLOCK_BYTES);
        if (need == 0)
        begin
            o.ok = 1'b1;
            o.status = ffba_pkg::ST_OK;
            return o;
        end
        if (head >= 64'(pool_size) || need > 64'(pool_size) - head)
            return o;
        if (chunk_count >= MAX_CHUNKS)
        begin
            o.status = ffba_pkg::ST_FULL;
            return o;
        end
        // Insert after any chunk with an equal head, then merge touching pairs.
        pos = 0;
        while (pos < chunk_count && 64'(chunk_head[pos]) <= head)
            pos++;
        for (int j = chunk_count; j > pos; j--)
        begin
            chunk_head[j] = chunk_head[j - 1];
            chunk_len[j]  = chunk_len[j - 1];
        end
        chunk_head[pos] = (START_W + 1)'(head);
        chunk_len[pos]  = (LEN_W + 1)'(need);
        chunk_count++;
        p = 0;
        c = 1;
        while (c < chunk_count)
        begin
            if (64'(chunk_head[p]) + 64'(chunk_len[p]) == 64'(chunk_head[c]))
            begin
                chunk_len[p] = chunk_len[p] + chunk_len[c];
                for (int j = c; j < chunk_count - 1; j++)
                begin
                    chunk_head[j] = chunk_head[j + 1];
                    chunk_len[j]  = chunk_len[j + 1];
                end
                chunk_count--;
            end
            else
            begin
                p++;
                c++;
            end
        end
        o.ok = 1'b1;
        o.status = ffba_pkg::ST_OK;
        return o;
    endfunction

    // Response checker: compare every accepted response against the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin : check_response
        ffba_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                broken = 1'b1;
                mismatch_count++;
                if (mismatch_count <= SHOWN_MAX)
                    $display("unexpected response: ok=%0b addr=%h status=%0d",
                             out_data.ok, out_data.granted_address, out_data.status);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (out_data.ok !== want.ok
                    || out_data.granted_address !== want.granted_address
                    || out_data.status !== want.status)
                begin
                    broken = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MAX)
                        $display({"mismatch: expected ok=%0b addr=%h status=%0d,",
                                  " got ok=%0b addr=%h status=%0d"},
                                 want.ok, want.granted_address, want.status,
                                 out_data.ok, out_data.granted_address, out_data.status);
                end
            end
        end
    end

    // Drive one request transaction; hold valid and payload until accepted.
    // Valid stays up after acceptance; the next idle cycle or drain drops it.
    task automatic issue(input ffba_pkg::req_t r, output ffba_pkg::rsp_t got);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        got = predict_grant(r);
        pending_grants.insert(pending_grants.size(), got);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_alloc(input logic [SIZE_W-1:0] nbytes);
        ffba_pkg::req_t r;
        ffba_pkg::rsp_t g;
        r.cmd = ffba_pkg::CMD_ALLOC;
        r.size_bytes = nbytes;
        r.block_address = ADDR_W'({$urandom, $urandom});
        issue(r, g);
        if (g.ok && nbytes != '0)
        begin
            live_addr.insert(live_addr.size(), g.granted_address);
            live_bytes.insert(live_bytes.size(), nbytes);
        end
    endtask

    task automatic send_free(input logic [SIZE_W-1:0] nbytes, input logic [ADDR_W-1:0] a);
        ffba_pkg::req_t r;
        ffba_pkg::rsp_t g;
        r.cmd = ffba_pkg::CMD_FREE;
        r.size_bytes = nbytes;
        r.block_address = a;
        issue(r, g);
    endtask

    // Carve single blocks, then release every other one to push the list to
    // its limit, so the frees past it are refused as list full; then release the rest.
    task automatic fragment_pool();
        int n;
        int first;
        n = (int'(pool_size) > 2 * MAX_CHUNKS + 8) ? 2 * MAX_CHUNKS + 4 : 0;
        first = live_addr.size();
        for (int k = 0; k < n; k++)
            send_alloc(SIZE_W'(BLOCK_BYTES));
        for (int k = first; k < live_addr.size(); k += 2)
            send_free(live_bytes[k], live_addr[k]);
        for (int k = first + 1; k < live_addr.size(); k += 2)
            send_free(live_bytes[k], live_addr[k]);
        while (live_addr.size() > first)
        begin
            void'(live_addr.pop_back());
            void'(live_bytes.pop_back());
        end
    endtask

    task automatic random_traffic(input int count);
        int                sel;
        int                pick;
        logic [31:0]       top;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(99);
            top = (32'(pool_size) / 32'd8 + 32'd1) * 32'(BLOCK_BYTES);
            if (top > 32'(POOL_MAX * BLOCK_BYTES))
                top = 32'(POOL_MAX * BLOCK_BYTES);
            if (sel < 45)
            begin
                send_alloc(SIZE_W'($urandom_range(top)));
            end
            else if (sel < 85 && live_addr.size() != 0)
            begin
                pick = $urandom_range(live_addr.size() - 1);
                send_free(live_bytes[pick], live_addr[pick]);
                live_addr.delete(pick);
                live_bytes.delete(pick);
            end
            else if (sel < 92)
            begin
                // Oversized, near-pool and misaligned sizes.
                sz = SIZE_W'($urandom_range(POOL_MAX * BLOCK_BYTES));
                send_alloc(sz);
            end
            else
            begin
                // Noise: any command, any size, address random or near the pool.
                sz = SIZE_W'($urandom_range(POOL_MAX * BLOCK_BYTES));
                if ($urandom_range(1))
                    sz = SIZE_W'(32'(sz) % (top + 32'd1));
                a = ADDR_W'({$urandom, $urandom});
                if ($urandom_range(1))
                    a = pool_base
                      + ADDR_W'($urandom_range(32'(pool_size) * 32'(BLOCK_BYTES) + 32'd511));
                if ($urandom_range(1))
                    send_free(sz, a);
                else
                    send_alloc(sz);
            end
        end
    endtask

    function automatic void add_row(logic cmd, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a,
                                    bit typed, ffba_pkg::rsp_t want);
        row_t row;
        row.cmd           = cmd;
        row.size_bytes    = sz;
        row.block_address = a;
        row.typed         = typed;
        row.want          = want;
        rows.insert(rows.size(), row);
    endfunction

    task automatic run_table();
        ffba_pkg::req_t r;
        ffba_pkg::rsp_t g;
        ffba_pkg::rsp_t nofit;
        ffba_pkg::rsp_t zero_ok;
        ffba_pkg::rsp_t second_block;
        nofit        = '{ok: 1'b0, granted_address: '0, status: ffba_pkg::ST_NOFIT};
        zero_ok      = '{ok: 1'b1, granted_address: '0, status: ffba_pkg::ST_OK};
        second_block = '{ok: 1'b1, granted_address: 48'h100, status: ffba_pkg::ST_OK};
        // After reset: one chunk of 16384 blocks at base zero.
        add_row(ffba_pkg::CMD_ALLOC, 29'd0, 48'h0, 1'b1, zero_ok);
        add_row(ffba_pkg::CMD_ALLOC, 29'd256, 48'h0, 1'b1, zero_ok);
        add_row(ffba_pkg::CMD_ALLOC, 29'd1, 48'h0, 1'b1, second_block);
        add_row(ffba_pkg::CMD_ALLOC, 29'd268435456, 48'h0, 1'b1, nofit);
        add_row(ffba_pkg::CMD_ALLOC, 29'(16383 * 256), 48'h0, 1'b1, nofit);
        add_row(ffba_pkg::CMD_FREE, 29'd0, 48'h1234_5678_9ABC, 1'b1, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'h0, 1'b1, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'h100, 1'b1, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'(16384 * 256), 1'b1, nofit);
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'hFFFF_FFFF_FFFF, 1'b1, nofit);
        add_row(ffba_pkg::CMD_FREE, 29'd268435456, 48'h0, 1'b1, nofit);
        add_row(ffba_pkg::CMD_FREE, 29'h1FF_FFFF, 48'h0, 1'b0, zero_ok);
        // Misaligned free rounds down to its block.
        add_row(ffba_pkg::CMD_ALLOC, 29'd512, 48'h0, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'd512, 48'h7F, 1'b0, zero_ok);
        // Drain the pool, then hit the empty list.
        add_row(ffba_pkg::CMD_ALLOC, 29'(16384 * 256), 48'h0, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_ALLOC, 29'd0, 48'h0, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_ALLOC, 29'd256, 48'h0, 1'b0, zero_ok);
        // Overlapping frees at the same head: inserted, never merged.
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'h0, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'd256, 48'h0, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_FREE, 29'(100 * 256), 48'h200, 1'b0, zero_ok);
        add_row(ffba_pkg::CMD_ALLOC, 29'(50 * 256 + 3), 48'h0, 1'b0, zero_ok);
        foreach (rows[k])
        begin
            r.cmd = rows[k].cmd;
            r.size_bytes = rows[k].size_bytes;
            r.block_address = rows[k].block_address;
            issue(r, g);
            if (rows[k].typed && g !== rows[k].want)
            begin
                broken = 1'b1;
                $display("table row %0d: predictor disagrees with typed response", k);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = ffba_pkg::REG_BASE_ADDRESS;
        cfg_data = '0;
        sender_idle_pct = 0;
        sink_stall_pct = 0;
        pool_base = '0;
        pool_size = LEN_W'(ffba_pkg::POOL_RESET);
        reset_list();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: reset settings, no idling.
        run_table();
        fragment_pool();
        random_traffic(200);

        // Phase 2: top of address space, pool saturated up to one block;
        // sender mostly idle.
        write_reg(ffba_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FF00);
        write_reg(ffba_pkg::REG_POOL_BLOCKS, 48'h0);
        live_addr.delete();
        live_bytes.delete();
        sender_idle_pct = 82;
        random_traffic(200);

        // Phase 3: largest pool, random base; receiver mostly stalled.
        write_reg(ffba_pkg::REG_BASE_ADDRESS, ADDR_W'({$urandom, $urandom}));
        write_reg(ffba_pkg::REG_POOL_BLOCKS, 48'hFFFF_FFFF_FFFF);
        live_addr.delete();
        live_bytes.delete();
        sender_idle_pct = 0;
        sink_stall_pct = 82;
        fragment_pool();
        random_traffic(190);

        // Phase 4: small pool of 300 blocks, both sides idling.
        write_reg(ffba_pkg::REG_BASE_ADDRESS, 48'h0000_0000_1234);
        write_reg(ffba_pkg::REG_POOL_BLOCKS, 48'd300);
        live_addr.delete();
        live_bytes.delete();
        sender_idle_pct = 26;
        sink_stall_pct = 26;
        fragment_pool();
        random_traffic(200);

        drain();
        if (pending_grants.size() != 0)
            broken = 1'b1;
        if (!broken)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
